// ===== src/bdq_pkg.sv =====
package bdq_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int DATA_W       = 32;
  localparam int ACTION_W     = 3;
  localparam int COUNT_W      = 6;
  localparam int KIND_W       = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_DELETE     = 3'd4,
    ACT_FIRST_N    = 3'd5,
    ACT_LAST_N     = 3'd6,
    ACT_ALL        = 3'd7
  } action_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ENTRY = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_NONE  = 2'd2,
    KIND_FULL  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STR_ALL   = 2'd0,
    STR_FIRST = 2'd1,
    STR_LAST  = 2'd2
  } str_mode_t;

  typedef struct packed {
    logic      push_front;
    logic      push_back;
    logic      pop_front;
    logic      pop_back;
    logic      del_start;
    logic      del_run;
    logic      del_finish;
    logic      str_start;
    logic      str_run;
    str_mode_t str_mode;
    logic      note_load;
    kind_t     note_kind;
  } bdq_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic count_zero;
    logic count_over;
    logic out_free;
    logic scan_done;
  } bdq_stat_t;

endpackage

// ===== src/bdq_ram.sv =====
module bdq_ram #(
  parameter int WIDTH = bdq_pkg::DATA_W,
  parameter int DEPTH = bdq_pkg::CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/bdq_ctrl.sv =====
module bdq_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [bdq_pkg::ACTION_W-1:0]    action,
  input  bdq_pkg::bdq_stat_t              stat,
  output bdq_pkg::bdq_cmd_t               cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_NOTE,
    S_DEL,
    S_STREAM
  } state_t;

  state_t          state;
  state_t          state_next;
  bdq_pkg::kind_t  note_kind;
  bdq_pkg::kind_t  note_kind_next;
  bdq_pkg::action_t act;
  logic            accept;

  assign act      = bdq_pkg::action_t'(action);
  assign in_stall = (state != S_IDLE);
  assign accept   = (state == S_IDLE) && in_valid;

  always_comb begin
    cmd            = '0;
    cmd.str_mode   = bdq_pkg::STR_ALL;
    cmd.note_kind  = note_kind;
    state_next     = state;
    note_kind_next = note_kind;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (act)
            bdq_pkg::ACT_PUSH_FRONT, bdq_pkg::ACT_PUSH_BACK: begin
              if (stat.full) begin
                note_kind_next = bdq_pkg::KIND_FULL;
                state_next     = S_NOTE;
              end else begin
                cmd.push_front = (act == bdq_pkg::ACT_PUSH_FRONT);
                cmd.push_back  = (act == bdq_pkg::ACT_PUSH_BACK);
              end
            end
            bdq_pkg::ACT_POP_FRONT, bdq_pkg::ACT_POP_BACK: begin
              if (stat.empty) begin
                note_kind_next = bdq_pkg::KIND_EMPTY;
                state_next     = S_NOTE;
              end else begin
                cmd.pop_front = (act == bdq_pkg::ACT_POP_FRONT);
                cmd.pop_back  = (act == bdq_pkg::ACT_POP_BACK);
              end
            end
            bdq_pkg::ACT_DELETE: begin
              cmd.del_start = 1'b1;
              state_next    = S_DEL;
            end
            bdq_pkg::ACT_FIRST_N, bdq_pkg::ACT_LAST_N, bdq_pkg::ACT_ALL: begin
              priority if (stat.empty) begin
                note_kind_next = bdq_pkg::KIND_EMPTY;
                state_next     = S_NOTE;
              end else if (act == bdq_pkg::ACT_ALL || stat.count_over) begin
                cmd.str_start = 1'b1;
                cmd.str_mode  = bdq_pkg::STR_ALL;
                state_next    = S_STREAM;
              end else if (stat.count_zero) begin
                note_kind_next = bdq_pkg::KIND_NONE;
                state_next     = S_NOTE;
              end else begin
                cmd.str_start = 1'b1;
                cmd.str_mode  = (act == bdq_pkg::ACT_FIRST_N) ? bdq_pkg::STR_FIRST
                                                              : bdq_pkg::STR_LAST;
                state_next    = S_STREAM;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_NOTE: begin
        if (stat.out_free) begin
          cmd.note_load = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_DEL: begin
        cmd.del_run = 1'b1;
        if (stat.scan_done) begin
          cmd.del_finish = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_STREAM: begin
        cmd.str_run = 1'b1;
        if (stat.scan_done) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      note_kind <= bdq_pkg::KIND_EMPTY;
    end else begin
      state     <= state_next;
      note_kind <= note_kind_next;
    end
  end

endmodule

// ===== src/bdq_dp.sv =====
module bdq_dp #(
  parameter int CAPACITY = bdq_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic signed [bdq_pkg::DATA_W-1:0]   value,
  input  logic [bdq_pkg::COUNT_W-1:0]         count,
  input  bdq_pkg::bdq_cmd_t                   cmd,
  output bdq_pkg::bdq_stat_t                  stat,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [bdq_pkg::KIND_W-1:0]          kind,
  output logic signed [bdq_pkg::DATA_W-1:0]   entry,
  output logic                                last_of_run
);

  localparam int IDXW = $clog2(CAPACITY);
  localparam int CNTW = $clog2(CAPACITY + 1);

  logic [IDXW-1:0]            head;
  logic [CNTW-1:0]            cnt;
  logic [bdq_pkg::DATA_W-1:0] req_value;
  logic [CNTW-1:0]            rd_off;
  logic [CNTW-1:0]            rd_end;
  logic                       rd_valid;
  logic                       rd_last;
  logic [CNTW-1:0]            kept;
  logic [bdq_pkg::KIND_W-1:0] kind_q;
  logic [bdq_pkg::DATA_W-1:0] entry_q;
  logic                       last_q;

  logic                       out_free;
  logic                       consume;
  logic                       issue;
  logic                       keep;
  logic [IDXW-1:0]            head_dec;
  logic [CNTW-1:0]            count_c;
  logic                       ram_we;
  logic [IDXW-1:0]            ram_waddr;
  logic [bdq_pkg::DATA_W-1:0] ram_wdata;
  logic [IDXW-1:0]            ram_raddr;
  logic [bdq_pkg::DATA_W-1:0] ram_rdata;

  function automatic logic [IDXW-1:0] pos(input logic [IDXW-1:0] h,
                                          input logic [CNTW-1:0] off);
    logic [CNTW:0] s;
    s = (CNTW+1)'(h) + (CNTW+1)'(off);
    if (s >= (CNTW+1)'(CAPACITY)) begin
      s = s - (CNTW+1)'(CAPACITY);
    end
    return s[IDXW-1:0];
  endfunction

  assign out_free = !out_valid || !out_stall;
  assign consume  = rd_valid && (cmd.del_run || (cmd.str_run && out_free));
  assign issue    = (cmd.str_run || cmd.del_run) && (rd_off != rd_end)
                    && (!rd_valid || consume);
  assign keep     = cmd.del_run && rd_valid && (ram_rdata != req_value);
  assign head_dec = (head == '0) ? IDXW'(CAPACITY - 1) : head - 1'b1;
  assign count_c  = CNTW'(count);

  assign stat.empty      = (cnt == '0);
  assign stat.full       = (cnt == CNTW'(CAPACITY));
  assign stat.count_zero = (count == '0);
  assign stat.count_over = (bdq_pkg::COUNT_W+1)'(count) > (bdq_pkg::COUNT_W+1)'(cnt);
  assign stat.out_free   = out_free;
  assign stat.scan_done  = (rd_off == rd_end) && !rd_valid;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = head_dec;
    ram_wdata = value;
    priority if (cmd.push_front) begin
      ram_we = 1'b1;
    end else if (cmd.push_back) begin
      ram_we    = 1'b1;
      ram_waddr = pos(head, cnt);
    end else if (keep) begin
      ram_we    = 1'b1;
      ram_waddr = pos(head, kept);
      ram_wdata = ram_rdata;
    end else begin
      ram_we = 1'b0;
    end
  end

  assign ram_raddr = pos(head, rd_off);

  bdq_ram #(
    .WIDTH (bdq_pkg::DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (issue),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      cnt       <= '0;
      rd_off    <= '0;
      rd_end    <= '0;
      rd_valid  <= 1'b0;
      kept      <= '0;
      out_valid <= 1'b0;
    end else begin
      priority if (cmd.push_front) begin
        head <= head_dec;
        cnt  <= cnt + 1'b1;
      end else if (cmd.push_back) begin
        cnt <= cnt + 1'b1;
      end else if (cmd.pop_front) begin
        head <= pos(head, CNTW'(1));
        cnt  <= cnt - 1'b1;
      end else if (cmd.pop_back) begin
        cnt <= cnt - 1'b1;
      end else if (cmd.del_finish) begin
        cnt <= kept;
      end else begin
        cnt <= cnt;
      end

      priority if (cmd.del_start) begin
        rd_off <= '0;
        rd_end <= cnt;
        kept   <= '0;
      end else if (cmd.str_start) begin
        unique case (cmd.str_mode)
          bdq_pkg::STR_FIRST: begin
            rd_off <= '0;
            rd_end <= count_c;
          end
          bdq_pkg::STR_LAST: begin
            rd_off <= cnt - count_c;
            rd_end <= cnt;
          end
          default: begin
            rd_off <= '0;
            rd_end <= cnt;
          end
        endcase
      end else begin
        if (issue) begin
          rd_off <= rd_off + 1'b1;
        end
        if (keep) begin
          kept <= kept + 1'b1;
        end
      end

      if (issue) begin
        rd_valid <= 1'b1;
      end else if (consume) begin
        rd_valid <= 1'b0;
      end

      if (cmd.note_load || (cmd.str_run && consume)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.del_start) begin
      req_value <= value;
    end
    if (issue) begin
      rd_last <= (rd_off + 1'b1 == rd_end);
    end
    if (cmd.note_load) begin
      kind_q  <= cmd.note_kind;
      entry_q <= '0;
      last_q  <= 1'b1;
    end else if (cmd.str_run && consume) begin
      kind_q  <= bdq_pkg::KIND_ENTRY;
      entry_q <= ram_rdata;
      last_q  <= rd_last;
    end
  end

  assign kind        = kind_q;
  assign entry       = $signed(entry_q);
  assign last_of_run = last_q;

  assert property (@(posedge clk) disable iff (rst) cnt <= CNTW'(CAPACITY))
    else $error("entry count beyond capacity");

  assert property (@(posedge clk) disable iff (rst) (IDXW+1)'(head) < (IDXW+1)'(CAPACITY))
    else $error("head index out of range");

  assert property (@(posedge clk) disable iff (rst) rd_off <= rd_end)
    else $error("scan offset passed its end");

  assert property (@(posedge clk) disable iff (rst) cmd.del_run |-> kept <= rd_off)
    else $error("compaction write overtook read");

  assert property (@(posedge clk) disable iff (rst)
                   (rd_valid && !consume && !issue) |=> rd_valid)
    else $error("pending read beat lost");

endmodule

// ===== src/bounded_deque_with_value_removal.sv =====
// Bounded double-ended queue of signed 32-bit entries held in list order in a
// circular RAM with one write port and one registered read port. A successful push
// or pop gives no beat. A push onto a full list, a pop or print on an empty one, or a
// print of zero entries holds the input and gives a single status beat once the
// output register is free. A delete-by-value scans and compacts the list in place,
// one entry a cycle over the RAM read port, and holds the input until the scan is
// done. A print of N entries (of all entries when N exceeds the entry count) streams
// one beat a cycle once the RAM read latency is covered and while the output side
// does not stall, and the final beat carries last_of_run. A new request is taken
// while the last beat of the previous one still waits in the output register.
module bounded_deque_with_value_removal #(
  parameter int CAPACITY = bdq_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [bdq_pkg::ACTION_W-1:0]      action,
  input  logic signed [bdq_pkg::DATA_W-1:0] value,
  input  logic [bdq_pkg::COUNT_W-1:0]       count,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [bdq_pkg::KIND_W-1:0]        kind,
  output logic signed [bdq_pkg::DATA_W-1:0] entry,
  output logic                              last_of_run
);

  bdq_pkg::bdq_cmd_t  cmd;
  bdq_pkg::bdq_stat_t stat;

  bdq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .action   (action),
    .stat     (stat),
    .cmd      (cmd)
  );

  bdq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .value       (value),
    .count       (count),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .entry       (entry),
    .last_of_run (last_of_run)
  );

endmodule
